// File: src/rbgr_pkg.sv
// Shared types and constants for the red-black grid relaxation unit.
// No dependencies; rbgr_relax and the top-level unit import this package.
package rbgr_pkg;

    localparam int DEF_MAX_SIDE  = 64;
    localparam int DEF_FRAC_BITS = 16;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_LOADED  = 2'd0;
    localparam logic [1:0] STAT_READ    = 2'd1;
    localparam logic [1:0] STAT_DONE    = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    // Boundary modes.
    localparam logic [1:0] BMODE_XWALL = 2'd1;
    localparam logic [1:0] BMODE_YWALL = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GRID_SIDE     = 3'd0;
    localparam logic [2:0] CFG_SWEEP_COUNT   = 3'd1;
    localparam logic [2:0] CFG_BOUNDARY_MODE = 3'd2;
    localparam logic [2:0] CFG_COUPLING      = 3'd3;
    localparam logic [2:0] CFG_INV_CENTER    = 3'd4;

    // Configuration reset values.
    localparam logic [6:0]  RST_GRID_SIDE     = 7'd64;
    localparam logic [6:0]  RST_SWEEP_COUNT   = 7'd20;
    localparam logic [1:0]  RST_BOUNDARY_MODE = 2'd0;
    localparam logic [30:0] RST_COUPLING      = 31'd0;
    localparam logic [16:0] RST_INV_CENTER    = 17'd65536;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RUN_DONE,
        ST_CELL_RD,
        ST_CELL_N0,
        ST_CELL_N1,
        ST_CELL_N2,
        ST_CELL_N3,
        ST_CELL_WAIT,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_CORN_A,
        ST_CORN_B,
        ST_CORN_WR,
        ST_ZERO_RD,
        ST_ZERO_WR
    } rbgr_state_t;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_MUL_LO,
        RX_MUL_HI,
        RX_TERM,
        RX_TOTAL,
        RX_MUL2_LO,
        RX_MUL2_HI,
        RX_RESULT
    } rbgr_rx_state_t;

    typedef struct packed {
        logic               start;
        logic signed [34:0] sum;
        logic signed [31:0] src;
    } relax_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } relax_rsp_t;

endpackage

// File: src/rbgr_if.sv
// Channel interfaces of the red-black grid relaxation unit: input items,
// result items and configuration writes. No dependencies.
interface rbgr_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [5:0]         col;
    logic [5:0]         row;
    logic signed [31:0] cell_value;
    logic signed [31:0] source_value;
    logic               solid;

    modport source (output valid, kind, col, row, cell_value, source_value, solid,
                    input ready);
    modport sink (input valid, kind, col, row, cell_value, source_value, solid,
                  output ready);
endinterface

interface rbgr_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [1:0]         status;

    modport source (output valid, read_value, status, input ready);
    modport sink (input valid, read_value, status, output ready);
endinterface

interface rbgr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/rbgr_relax.sv
// Shared-multiplier datapath that computes one relaxed cell value.
// Depends on rbgr_pkg for the request/response structs and state enum.
module rbgr_relax
    import rbgr_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [30:0] coupling,
    input  logic [16:0] inv_center,
    input  relax_req_t  req,
    output relax_rsp_t  rsp
);

    localparam logic [62:0] FRAC_MASK = 63'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [64:0] POS45_MAX = 65'h1FFF_FFFF_FFFF;
    localparam logic [64:0] NEG45_MAG = 65'h2000_0000_0000;
    localparam logic [64:0] POS31_MAX = 65'h7FFF_FFFF;
    localparam logic [64:0] NEG31_MAG = 65'h8000_0000;
    localparam logic signed [47:0] TOT_MAX = 48'sh1FFF_FFFF_FFFF;
    localparam logic signed [47:0] TOT_MIN = -48'sh2000_0000_0000;

    rbgr_rx_state_t     state_reg, state_next;
    logic [33:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] src_reg, src_next;
    logic [62:0]        prod_reg;
    logic [62:0]        plo_reg, plo_next;
    logic signed [46:0] term_reg, term_next;
    logic [45:0]        tmag_reg, tmag_next;
    logic               tneg_reg, tneg_next;

    logic [30:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        p_full;
    logic [64:0]        q;
    logic [64:0]        qc;
    logic signed [47:0] tot;
    logic signed [47:0] tot_c;

    // The full product is hi << 32 plus lo; the quotient is floored, and for
    // negative operands the magnitude is rounded up instead.
    assign p_full = {prod_reg[32:0], 32'b0} + {2'b0, plo_reg};
    assign q      = p_full >> FRAC_BITS;
    assign qc     = q + 65'(|(plo_reg & FRAC_MASK));
    assign tot    = {{16{src_reg[31]}}, src_reg} + {term_reg[46], term_reg};

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        src_next   = src_reg;
        plo_next   = plo_reg;
        term_next  = term_reg;
        tmag_next  = tmag_reg;
        tneg_next  = tneg_reg;
        mul_a      = coupling;
        mul_b      = mag_reg[31:0];
        rsp.done   = 1'b0;
        rsp.value  = '0;
        tot_c      = tot;
        unique case (state_reg)
            RX_IDLE:
            begin
                if (req.start)
                begin
                    neg_next   = req.sum[34];
                    mag_next   = req.sum[34] ? 34'(-req.sum) : 34'(req.sum);
                    src_next   = req.src;
                    state_next = RX_MUL_LO;
                end
            end
            RX_MUL_LO:
            begin
                state_next = RX_MUL_HI;
            end
            RX_MUL_HI:
            begin
                mul_b      = {30'b0, mag_reg[33:32]};
                plo_next   = prod_reg;
                state_next = RX_TERM;
            end
            RX_TERM:
            begin
                if (neg_reg)
                    term_next = (qc > NEG45_MAG) ? -47'sh2000_0000_0000 : -(47'(qc));
                else
                    term_next = (q > POS45_MAX) ? 47'sh1FFF_FFFF_FFFF : 47'(q);
                state_next = RX_TOTAL;
            end
            RX_TOTAL:
            begin
                if (tot > TOT_MAX)
                    tot_c = TOT_MAX;
                else if (tot < TOT_MIN)
                    tot_c = TOT_MIN;
                tneg_next  = tot_c[47];
                tmag_next  = tot_c[47] ? 46'(-tot_c) : 46'(tot_c);
                state_next = RX_MUL2_LO;
            end
            RX_MUL2_LO:
            begin
                mul_a      = {14'b0, inv_center};
                mul_b      = tmag_reg[31:0];
                state_next = RX_MUL2_HI;
            end
            RX_MUL2_HI:
            begin
                mul_a      = {14'b0, inv_center};
                mul_b      = {18'b0, tmag_reg[45:32]};
                plo_next   = prod_reg;
                state_next = RX_RESULT;
            end
            RX_RESULT:
            begin
                rsp.done = 1'b1;
                if (tneg_reg)
                    rsp.value = (qc > NEG31_MAG) ? 32'sh8000_0000 : -(32'(qc));
                else
                    rsp.value = (q > POS31_MAX) ? 32'sh7FFF_FFFF : 32'(q);
                state_next = RX_IDLE;
            end
            default:
            begin
                state_next = RX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= RX_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'b0, mul_a} * {31'b0, mul_b};
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        src_reg  <= src_next;
        plo_reg  <= plo_next;
        term_reg <= term_next;
        tmag_reg <= tmag_next;
        tneg_reg <= tneg_next;
    end

endmodule

// File: src/red_black_grid_relaxation_unit.sv
// Red-black grid relaxation unit. Items are taken one at a time, only in the idle state:
// a load answers in the next cycle, a read after its registered memory read in ST_READ.
// In a run each fluid interior cell reads its four neighbours through the single read port
// of the unknown grid and then waits on the shared multiplier; each sweep adds the edge
// copy, corners and a solid-zeroing pass.
// After reset the whole solid map is cleared before items are taken.
module red_black_grid_relaxation_unit
    import rbgr_pkg::*;
#(
    parameter int MAX_SIDE  = DEF_MAX_SIDE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    rbgr_item_if.sink    item,
    rbgr_result_if.source result,
    rbgr_cfg_if.sink     cfg
);

    localparam int AW    = $clog2(MAX_SIDE);
    localparam int CW    = 2 * AW;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;

    // Configuration registers. Writes are taken at any time.
    logic [6:0]  grid_side_reg;
    logic [6:0]  sweep_count_reg;
    logic [1:0]  boundary_mode_reg;
    logic [30:0] coupling_reg;
    logic [16:0] inv_center_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg     <= RST_GRID_SIDE;
            sweep_count_reg   <= RST_SWEEP_COUNT;
            boundary_mode_reg <= RST_BOUNDARY_MODE;
            coupling_reg      <= RST_COUPLING;
            inv_center_reg    <= RST_INV_CENTER;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GRID_SIDE:     grid_side_reg     <= cfg.data[6:0];
                CFG_SWEEP_COUNT:   sweep_count_reg   <= cfg.data[6:0];
                CFG_BOUNDARY_MODE: boundary_mode_reg <= cfg.data[1:0];
                CFG_COUPLING:      coupling_reg      <= cfg.data[30:0];
                CFG_INV_CENTER:    inv_center_reg    <= cfg.data[16:0];
                default:           ;
            endcase
        end
    end

    // Effective last index of the grid in use: the side clamps to 4 .. MAX_SIDE.
    logic [AW-1:0] last;

    always_comb
    begin
        if (grid_side_reg < 7'd4)
            last = AW'(3);
        else if (32'(grid_side_reg) > MAX_SIDE)
            last = AW'(MAX_SIDE - 1);
        else
            last = AW'(grid_side_reg - 7'd1);
    end

    // Grid memories, addressed as {row, col}. The unknown grid has one read and one
    // write port; reads are registered.
    logic [31:0] unk_mem [CELLS];
    logic [31:0] src_mem [CELLS];
    logic        sol_mem [CELLS];

    logic          unk_we;
    logic [CW-1:0] unk_waddr;
    logic [31:0]   unk_wdata;
    logic [CW-1:0] unk_raddr;
    logic [31:0]   unk_q;
    logic          src_we;
    logic [CW-1:0] src_raddr;
    logic [31:0]   src_q;
    logic          sol_we;
    logic [CW-1:0] sol_waddr;
    logic          sol_wdata;
    logic [CW-1:0] sol_raddr;
    logic          sol_q;

    always_ff @(posedge clk)
    begin
        if (unk_we)
            unk_mem[unk_waddr] <= unk_wdata;
        unk_q <= unk_mem[unk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
            src_mem[unk_waddr] <= item.source_value;
        src_q <= src_mem[src_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sol_we)
            sol_mem[sol_waddr] <= sol_wdata;
        sol_q <= sol_mem[sol_raddr];
    end

    // Sequencer registers.
    rbgr_state_t        state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [6:0]         sweep_reg, sweep_next;
    logic               color_reg, color_next;
    logic [AW-1:0]      r_reg, r_next;
    logic [AW-1:0]      c_reg, c_next;
    logic [1:0]         part_reg, part_next;
    logic [31:0]        hold_reg, hold_next;
    logic signed [34:0] sum_reg, sum_next;
    logic [CW-1:0]      clr_reg, clr_next;

    relax_req_t relax_req;
    relax_rsp_t relax_rsp;

    rbgr_relax #(
        .FRAC_BITS (FRAC_BITS)
    ) u_relax (
        .clk        (clk),
        .rst_n      (rst_n),
        .coupling   (coupling_reg),
        .inv_center (inv_center_reg),
        .req        (relax_req),
        .rsp        (relax_rsp)
    );

    // The result register frees as soon as the sink takes it, so a new item may be
    // accepted in the same cycle a waiting result transfers.
    logic out_free;
    logic in_range;
    logic [CW-1:0] load_addr;
    logic signed [34:0] unk_ext;

    assign out_free   = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == ST_IDLE) && out_free;
    assign in_range   = (32'(item.col) <= 32'(last)) && (32'(item.row) <= 32'(last));
    assign load_addr  = {AW'(item.row), AW'(item.col)};
    assign unk_ext    = {{3{unk_q[31]}}, unk_q};

    assign result.valid      = out_valid_reg;
    assign result.read_value = out_value_reg;
    assign result.status     = out_status_reg;

    // Step to the next cell of the current color. A row's first cell of that color
    // sits at column 1 when column plus row is even for red, odd for black.
    logic [AW:0]   c_plus2;
    logic [AW:0]   r_plus1;
    logic [AW:0]   c_plus1;
    rbgr_state_t   adv_state;
    logic [AW-1:0] adv_r;
    logic [AW-1:0] adv_c;
    logic          adv_color;

    assign c_plus2 = {1'b0, c_reg} + (AW+1)'(2);
    assign c_plus1 = {1'b0, c_reg} + (AW+1)'(1);
    assign r_plus1 = {1'b0, r_reg} + (AW+1)'(1);

    always_comb
    begin
        adv_state = ST_CELL_RD;
        adv_r     = r_reg;
        adv_c     = AW'(c_plus2);
        adv_color = color_reg;
        if (c_plus2 >= {1'b0, last})
        begin
            if (r_plus1 < {1'b0, last})
            begin
                adv_r = AW'(r_plus1);
                adv_c = ((r_reg[0]) == color_reg) ? AW'(1) : AW'(2);
            end
            else if (!color_reg)
            begin
                adv_color = 1'b1;
                adv_r     = AW'(1);
                adv_c     = AW'(2);
            end
            else
            begin
                adv_state = ST_EDGE_RD;
                adv_r     = AW'(1);
                adv_c     = c_reg;
            end
        end
    end

    // Edge and corner addressing: part selects the wall or the corner.
    logic [CW-1:0] edge_addr;
    logic [CW-1:0] inner_addr;
    logic          wall_neg;
    logic [CW-1:0] corn_dst;
    logic [CW-1:0] corn_a;
    logic [CW-1:0] corn_b;
    logic [AW-1:0] last_m1;

    assign last_m1 = last - AW'(1);

    always_comb
    begin
        unique case (part_reg)
            2'd0:
            begin
                edge_addr  = {AW'(0), r_reg};
                inner_addr = {AW'(1), r_reg};
                wall_neg   = (boundary_mode_reg == BMODE_YWALL);
                corn_dst   = {AW'(0), AW'(0)};
                corn_a     = {AW'(0), AW'(1)};
                corn_b     = {AW'(1), AW'(0)};
            end
            2'd1:
            begin
                edge_addr  = {last, r_reg};
                inner_addr = {last_m1, r_reg};
                wall_neg   = (boundary_mode_reg == BMODE_YWALL);
                corn_dst   = {last, AW'(0)};
                corn_a     = {last, AW'(1)};
                corn_b     = {last_m1, AW'(0)};
            end
            2'd2:
            begin
                edge_addr  = {r_reg, AW'(0)};
                inner_addr = {r_reg, AW'(1)};
                wall_neg   = (boundary_mode_reg == BMODE_XWALL);
                corn_dst   = {AW'(0), last};
                corn_a     = {AW'(0), last_m1};
                corn_b     = {AW'(1), last};
            end
            default:
            begin
                edge_addr  = {r_reg, last};
                inner_addr = {r_reg, last_m1};
                wall_neg   = (boundary_mode_reg == BMODE_XWALL);
                corn_dst   = {last, last};
                corn_a     = {last, last_m1};
                corn_b     = {last_m1, last};
            end
        endcase
    end

    // Negation saturates the most negative value; corners take the floored mean.
    logic [31:0]        flipped;
    logic signed [32:0] half_sum;

    assign flipped  = (sol_q || wall_neg)
                      ? ((unk_q == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'(-unk_q))
                      : unk_q;
    assign half_sum = {hold_reg[31], hold_reg} + {unk_q[31], unk_q};

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        sweep_next      = sweep_reg;
        color_next      = color_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        part_next       = part_reg;
        hold_next       = hold_reg;
        sum_next        = sum_reg;
        clr_next        = clr_reg;
        unk_we          = 1'b0;
        unk_waddr       = {r_reg, c_reg};
        unk_wdata       = '0;
        unk_raddr       = {r_reg, c_reg};
        src_we          = 1'b0;
        src_raddr       = {r_reg, c_reg};
        sol_we          = 1'b0;
        sol_waddr       = clr_reg;
        sol_wdata       = 1'b0;
        sol_raddr       = {r_reg, c_reg};
        relax_req.start = 1'b0;
        relax_req.sum   = sum_reg + unk_ext;
        relax_req.src   = src_q;

        unique case (state_reg)
            ST_CLEAR:
            begin
                sol_we   = 1'b1;
                clr_next = clr_reg + CW'(1);
                if (&clr_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                unk_raddr = load_addr;
                if (item.valid && out_free)
                begin
                    out_value_next = '0;
                    if (item.kind == KIND_RUN)
                    begin
                        sweep_next = '0;
                        color_next = 1'b0;
                        r_next     = AW'(1);
                        c_next     = AW'(1);
                        part_next  = 2'd0;
                        if (sweep_count_reg == 7'd0)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_DONE;
                        end
                        else
                            state_next = ST_CELL_RD;
                    end
                    else if (item.kind == KIND_LOAD && in_range)
                    begin
                        unk_we          = 1'b1;
                        unk_waddr       = load_addr;
                        unk_wdata       = item.cell_value;
                        src_we          = 1'b1;
                        sol_we          = 1'b1;
                        sol_waddr       = load_addr;
                        sol_wdata       = item.solid;
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_LOADED;
                    end
                    else if (item.kind == KIND_READ && in_range)
                        state_next = ST_READ;
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_IGNORED;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = unk_q;
                out_status_next = STAT_READ;
                state_next      = ST_IDLE;
            end
            ST_RUN_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = STAT_DONE;
                    state_next      = ST_IDLE;
                end
            end
            ST_CELL_RD:
            begin
                unk_raddr  = {r_reg, c_reg + AW'(1)};
                state_next = ST_CELL_N0;
            end
            ST_CELL_N0:
            begin
                if (sol_q)
                begin
                    state_next = adv_state;
                    r_next     = adv_r;
                    c_next     = adv_c;
                    color_next = adv_color;
                end
                else
                begin
                    sum_next   = unk_ext;
                    unk_raddr  = {r_reg, c_reg - AW'(1)};
                    state_next = ST_CELL_N1;
                end
            end
            ST_CELL_N1:
            begin
                sum_next   = sum_reg + unk_ext;
                unk_raddr  = {r_reg + AW'(1), c_reg};
                state_next = ST_CELL_N2;
            end
            ST_CELL_N2:
            begin
                sum_next   = sum_reg + unk_ext;
                unk_raddr  = {r_reg - AW'(1), c_reg};
                state_next = ST_CELL_N3;
            end
            ST_CELL_N3:
            begin
                relax_req.start = 1'b1;
                state_next      = ST_CELL_WAIT;
            end
            ST_CELL_WAIT:
            begin
                if (relax_rsp.done)
                begin
                    unk_we     = 1'b1;
                    unk_wdata  = relax_rsp.value;
                    state_next = adv_state;
                    r_next     = adv_r;
                    c_next     = adv_c;
                    color_next = adv_color;
                    part_next  = 2'd0;
                end
            end
            ST_EDGE_RD:
            begin
                unk_raddr  = inner_addr;
                sol_raddr  = edge_addr;
                state_next = ST_EDGE_WR;
            end
            ST_EDGE_WR:
            begin
                unk_we     = 1'b1;
                unk_waddr  = edge_addr;
                unk_wdata  = flipped;
                part_next  = part_reg + 2'd1;
                state_next = ST_EDGE_RD;
                if (part_reg == 2'd3)
                begin
                    if (r_plus1 >= {1'b0, last})
                        state_next = ST_CORN_A;
                    else
                        r_next = AW'(r_plus1);
                end
            end
            ST_CORN_A:
            begin
                unk_raddr  = corn_a;
                state_next = ST_CORN_B;
            end
            ST_CORN_B:
            begin
                hold_next  = unk_q;
                unk_raddr  = corn_b;
                state_next = ST_CORN_WR;
            end
            ST_CORN_WR:
            begin
                unk_we     = 1'b1;
                unk_waddr  = corn_dst;
                unk_wdata  = half_sum[32:1];
                part_next  = part_reg + 2'd1;
                state_next = ST_CORN_A;
                if (part_reg == 2'd3)
                begin
                    r_next     = AW'(1);
                    c_next     = AW'(1);
                    state_next = ST_ZERO_RD;
                end
            end
            ST_ZERO_RD:
            begin
                state_next = ST_ZERO_WR;
            end
            ST_ZERO_WR:
            begin
                unk_we     = sol_q;
                unk_wdata  = '0;
                c_next     = AW'(c_plus1);
                state_next = ST_ZERO_RD;
                if (c_plus1 >= {1'b0, last})
                begin
                    c_next = AW'(1);
                    r_next = AW'(r_plus1);
                    if (r_plus1 >= {1'b0, last})
                    begin
                        // End of one sweep.
                        sweep_next = sweep_reg + 7'd1;
                        color_next = 1'b0;
                        r_next     = AW'(1);
                        c_next     = AW'(1);
                        if ({1'b0, sweep_reg} + 8'd1 >= {1'b0, sweep_count_reg})
                            state_next = ST_RUN_DONE;
                        else
                            state_next = ST_CELL_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        sweep_reg      <= sweep_next;
        color_reg      <= color_next;
        r_reg          <= r_next;
        c_reg          <= c_next;
        part_reg       <= part_next;
        hold_reg       <= hold_next;
        sum_reg        <= sum_next;
    end

endmodule
